// ----- rtl/core/scl_pkg.sv -----
// Shared types and constants for the set-associative LRU cache model.
// Used by every module under rtl/core but scl_fifo; depends on nothing.
`default_nettype none

package scl_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_W           = 32;
  localparam int APB_ADDR_W       = 4;

  // Access kinds; the fourth code makes no access.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  // Register byte addresses.
  localparam logic [APB_ADDR_W-1:0] REG_SET_BITS    = 4'h0;
  localparam logic [APB_ADDR_W-1:0] REG_WAYS_IN_USE = 4'h4;
  localparam logic [APB_ADDR_W-1:0] REG_OFFSET_BITS = 4'h8;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] ways_in_use;
    logic [4:0] offset_bits;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic        first_hit;
    logic        first_eviction;
    logic        second_done;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/scl_fifo.sv -----
// Small synchronous queue with push/full and pop/empty sides.
// Generic; no package dependency.
`default_nettype none

module scl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/scl_front.sv -----
// Front end: splits an accepted address into set index and tag.
// Depends on scl_pkg.
`default_nettype none

module scl_front #(
  parameter int MAX_SET_BITS = scl_pkg::MAX_SET_BITS_DEF,
  parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  scl_pkg::cfg_t             cfg_i,
  input  scl_pkg::item_t            item_i,
  output logic [1:0]                cmd_o,
  output logic [SET_W-1:0]          set_o,
  output logic [scl_pkg::ADDR_W-1:0] tag_o
);

  logic [2:0]                 s_eff;
  logic [5:0]                 sb;
  logic [scl_pkg::ADDR_W-1:0] shifted;
  logic [SET_W-1:0]           msk;

  always_comb begin
    // Saturate the set width to what the storage holds.
    s_eff = (32'(cfg_i.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_i.set_bits;
    sb    = 6'(s_eff) + 6'(cfg_i.offset_bits);
    for (int i = 0; i < SET_W; i++) begin
      msk[i] = (i < 32'(s_eff));
    end
    shifted = item_i.address >> cfg_i.offset_bits;
    set_o   = SET_W'(shifted) & msk;
    tag_o   = (sb < 6'(scl_pkg::ADDR_W)) ? (item_i.address >> sb) : '0;
    cmd_o   = item_i.command;
  end

endmodule

`default_nettype wire

// ----- rtl/core/scl_back.sv -----
// Back end: one read and one write-back of a set row per access, LRU update
// and running totals. Depends on scl_pkg.
`default_nettype none

module scl_back #(
  parameter int MAX_SET_BITS = scl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = scl_pkg::MAX_WAYS_DEF,
  parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scl_pkg::cfg_t              cfg_i,
  input  logic                       q_empty_i,
  input  logic [1:0]                 q_cmd_i,
  input  logic [SET_W-1:0]           q_set_i,
  input  logic [scl_pkg::ADDR_W-1:0] q_tag_i,
  output logic                       q_pop_o,
  input  logic                       res_full_i,
  output logic                       res_push_o,
  output scl_pkg::result_t           res_o
);

  localparam int SETS = 1 << MAX_SET_BITS;
  localparam int AW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WW   = AW;
  localparam int NW_W = $clog2(MAX_WAYS + 1);
  localparam int TW   = scl_pkg::ADDR_W;

  typedef struct packed {
    logic [MAX_WAYS-1:0]         valid;
    logic [MAX_WAYS-1:0][AW-1:0] age;
    logic [MAX_WAYS-1:0][TW-1:0] tag;
  } row_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_e;

  state_e            state_q, state_d;
  row_t              mem_q [SETS];
  row_t              rd_q, row, row_new;
  logic [SETS-1:0]   init_q;
  logic              init_rd_q;
  logic [1:0]        cmd_q;
  logic [SET_W-1:0]  set_q;
  logic [TW-1:0]     tag_q;
  logic [31:0]       hits_q, hits_d, miss_q, miss_d, evic_q, evic_d;

  logic [NW_W-1:0]   nw;
  logic              hit, free, evict, access, wr_en;
  logic [WW-1:0]     hit_way, free_way, vic_way, way;
  logic [AW-1:0]     best;
  logic [AW:0]       old;

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i && !res_full_i;

  always_comb begin
    nw = (cfg_i.ways_in_use == '0) ? NW_W'(1) : NW_W'(cfg_i.ways_in_use);
    if (32'(cfg_i.ways_in_use) > MAX_WAYS) begin
      nw = NW_W'(MAX_WAYS);
    end
    row = init_rd_q ? rd_q : '0;

    hit = 1'b0; hit_way = '0;
    free = 1'b0; free_way = '0;
    best = '0; vic_way = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (j < 32'(nw) && row.valid[j] && row.tag[j] == tag_q) begin
        hit = 1'b1; hit_way = WW'(j);
      end
      if (j < 32'(nw) && !row.valid[j]) begin
        free = 1'b1; free_way = WW'(j);
      end
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (j < 32'(nw) && row.age[j] > best) begin
        best = row.age[j]; vic_way = WW'(j);
      end
    end

    evict = !hit && !free;
    if (hit) begin
      way = hit_way; old = {1'b0, row.age[hit_way]};
    end else if (free) begin
      way = free_way; old = (AW + 1)'(MAX_WAYS);
    end else begin
      way = vic_way; old = {1'b0, row.age[vic_way]};
    end

    // Age only the ways in use; ways beyond the current count stay as they are.
    row_new = row;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (j < 32'(nw) && WW'(j) != way && row.valid[j] && {1'b0, row.age[j]} < old
          && row.age[j] < AW'(MAX_WAYS - 1)) begin
        row_new.age[j] = row.age[j] + 1'b1;
      end
    end
    row_new.valid[way] = 1'b1;
    row_new.tag[way]   = tag_q;
    row_new.age[way]   = '0;

    // The fourth command code makes no access and leaves the totals alone.
    access = (cmd_q == scl_pkg::CMD_LOAD) || (cmd_q == scl_pkg::CMD_STORE)
          || (cmd_q == scl_pkg::CMD_MODIFY);
    wr_en  = (state_q == ST_LOOK) && access;

    hits_d = hits_q; miss_d = miss_q; evic_d = evic_q;
    if (access) begin
      // The second access of a modify always hits and leaves the ages as they are.
      hits_d = hits_q + 32'(hit) + 32'(cmd_q == scl_pkg::CMD_MODIFY);
      miss_d = miss_q + 32'(!hit);
      evic_d = evic_q + 32'(evict);
    end

    res_o.first_hit      = access && hit;
    res_o.first_eviction = access && evict;
    res_o.second_done    = (cmd_q == scl_pkg::CMD_MODIFY);
    res_o.hit_total      = hits_d;
    res_o.miss_total     = miss_d;
    res_o.eviction_total = evic_d;
    res_push_o           = (state_q == ST_LOOK);

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_pop_o) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_q  <= '0;
      hits_q  <= '0;
      miss_q  <= '0;
      evic_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LOOK) begin
        hits_q <= hits_d;
        miss_q <= miss_d;
        evic_q <= evic_d;
      end
      if (wr_en) begin
        init_q[set_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q     <= q_cmd_i;
      set_q     <= q_set_i;
      tag_q     <= q_tag_i;
      rd_q      <= mem_q[q_set_i];
      init_rd_q <= init_q[q_set_i];
    end
    if (wr_en) begin
      mem_q[set_q] <= row_new;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/set_assoc_cache_lru_sim.sv -----
// Top level of the tag-only set-associative cache with LRU replacement.
// Depends on scl_pkg, scl_fifo, scl_front and scl_back.
//
// Input channel: drive item_i (command, address) and raise push; the item
// transfers on a rising edge with push high and full low.
// Result channel: while empty is low the oldest result sits on result_o;
// it transfers on a rising edge with pop high and empty low. One result
// per item: first-access hit and eviction flags, a flag for the second
// access of a modify, and the running hit, miss and eviction totals.
// Configuration: APB-style port, registers at byte 0 (set_bits), 4
// (ways_in_use), 8 (offset_bits); pready is always high. Write only while
// the block is idle.
// Flow: the front splits the address in the cycle of the push and queues
// it; the back reads the set row from its memory and writes it back in the
// cycle after, then pushes the result. The back takes no new item before
// the last is written back, set by the single read and write-back of a row.
// Reset: every line reads invalid with age 0 at once (one valid flag per
// row), totals clear, registers go to 4, 1, 4. A stalled receiver fills the
// two-entry result queue, then the back halts, then full rises.
`default_nettype none

module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = scl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = scl_pkg::MAX_WAYS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  scl_pkg::item_t                 item_i,
  output logic                           empty,
  input  logic                           pop,
  output scl_pkg::result_t               result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int QW    = 2 + SET_W + scl_pkg::ADDR_W;

  scl_pkg::cfg_t              cfg_q;
  logic                       cfg_wr;
  logic [1:0]                 f_cmd, q_cmd;
  logic [SET_W-1:0]           f_set, q_set;
  logic [scl_pkg::ADDR_W-1:0] f_tag, q_tag;
  logic                       q_empty, q_pop;
  logic                       res_full, res_push;
  scl_pkg::result_t           res;

  // Configuration registers: written in the access phase, read back as is.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits    <= 3'd4;
      cfg_q.ways_in_use <= 4'd1;
      cfg_q.offset_bits <= 5'd4;
    end else if (cfg_wr) begin
      unique case (paddr)
        scl_pkg::REG_SET_BITS:    cfg_q.set_bits    <= pwdata[2:0];
        scl_pkg::REG_WAYS_IN_USE: cfg_q.ways_in_use <= pwdata[3:0];
        scl_pkg::REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      scl_pkg::REG_SET_BITS:    prdata = 32'(cfg_q.set_bits);
      scl_pkg::REG_WAYS_IN_USE: prdata = 32'(cfg_q.ways_in_use);
      scl_pkg::REG_OFFSET_BITS: prdata = 32'(cfg_q.offset_bits);
      default:                  prdata = '0;
    endcase
  end

  // Front: classify the item and queue it for the back.
  scl_front #(.MAX_SET_BITS(MAX_SET_BITS), .SET_W(SET_W)) u_front (
    .cfg_i  (cfg_q),
    .item_i (item_i),
    .cmd_o  (f_cmd),
    .set_o  (f_set),
    .tag_o  (f_tag)
  );

  scl_fifo #(.WIDTH(QW), .DEPTH(2)) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_cmd, f_set, f_tag}),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  ({q_cmd, q_set, q_tag}),
    .empty_o (q_empty)
  );

  // Back: row read, LRU update, write-back, totals.
  scl_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .SET_W(SET_W)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_cmd),
    .q_set_i    (q_set),
    .q_tag_i    (q_tag),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // Result queue parts the back from a stalled receiver.
  scl_fifo #(.WIDTH($bits(scl_pkg::result_t)), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// ----- rtl/core/scl_checker.sv -----
// Port-level checks for set_assoc_cache_lru_sim, bound to the top level.
// Depends on scl_pkg.
`default_nettype none

module scl_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic             pready,
  input scl_pkg::result_t result_o
);

  a_ready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_empty_after_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result present right after reset");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("stalled result changed");

  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.first_eviction) |-> !result_o.first_hit)
    else $error("eviction flagged on a hit");

endmodule

bind set_assoc_cache_lru_sim scl_checker u_scl_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .pready   (pready),
  .result_o (result_o)
);

`default_nettype wire

// ----- tb/set_assoc_cache_lru_sim_tb.sv -----
// Self-checking testbench for the set-associative LRU cache model.
// Depends on scl_pkg and the set_assoc_cache_lru_sim top level.
`timescale 1ns / 100ps

module set_assoc_cache_lru_sim_tb;

  localparam int LINES    = (1 << scl_pkg::MAX_SET_BITS_DEF) * scl_pkg::MAX_WAYS_DEF;
  localparam int AGE_TOP  = scl_pkg::MAX_WAYS_DEF - 1;
  localparam int N_RANDOM = 1300;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  scl_pkg::item_t item_i = '0;
  logic empty;
  logic pop = 1'b0;
  scl_pkg::result_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [scl_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  set_assoc_cache_lru_sim dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .result_o(result_o), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow cache: tags, valid flags, LRU ranks and the running totals.
  bit            sh_valid [LINES];
  logic [31:0]   sh_tag   [LINES];
  int unsigned   sh_age   [LINES];
  logic [31:0]   sh_hits, sh_misses, sh_evicts;
  scl_pkg::cfg_t sh_cfg;

  scl_pkg::item_t   pending_items[$];
  scl_pkg::result_t expected_results[$];
  int      error_count = 0;
  bit      stim_done = 0;

  // Idle controls: bursty and the holds set by the stimulus thread, gaps by driver and monitor.
  bit      bursty = 1;
  bit      sender_hold = 0;
  bit      receiver_hold = 0;
  int      send_gap = 0;
  int      recv_gap = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // One lookup in the shadow; returns hit, flags an eviction.
  function automatic bit cache_access(input int unsigned set, input logic [31:0] tag,
                                      input int unsigned nways, output bit evicted);
    int unsigned base, way, old, best, j;
    bit found, hit;
    base = set * scl_pkg::MAX_WAYS_DEF;
    way = 0; found = 0; hit = 0; evicted = 0; old = 0;
    for (j = 0; j < nways; j++)
      if (!found && sh_valid[base+j] && sh_tag[base+j] == tag) begin
        way = j; found = 1;
      end
    if (found) begin
      hit = 1; old = sh_age[base+way]; sh_hits++;
    end else begin
      sh_misses++;
      for (j = 0; j < nways; j++)
        if (!found && !sh_valid[base+j]) begin
          way = j; found = 1;
        end
      if (found) begin
        old = AGE_TOP + 1;
      end else begin
        best = 0; way = 0;
        for (j = 0; j < nways; j++)
          if (sh_age[base+j] > best) begin
            best = sh_age[base+j]; way = j;
          end
        old = sh_age[base+way];
        evicted = 1; sh_evicts++;
      end
    end
    for (j = 0; j < nways; j++)
      if (j != way && sh_valid[base+j] && sh_age[base+j] < old &&
          sh_age[base+j] < AGE_TOP)
        sh_age[base+j]++;
    sh_valid[base+way] = 1;
    sh_tag[base+way] = tag;
    sh_age[base+way] = 0;
    return hit;
  endfunction

  function automatic scl_pkg::result_t predict_lookup(input scl_pkg::item_t it);
    scl_pkg::result_t r;
    int unsigned s, nways, b, set;
    logic [31:0] tag;
    bit h1, e1, e2, dummy;
    s = (sh_cfg.set_bits > scl_pkg::MAX_SET_BITS_DEF) ? scl_pkg::MAX_SET_BITS_DEF
                                                      : sh_cfg.set_bits;
    nways = (sh_cfg.ways_in_use == 0) ? 1 : sh_cfg.ways_in_use;
    if (nways > scl_pkg::MAX_WAYS_DEF) nways = scl_pkg::MAX_WAYS_DEF;
    b = sh_cfg.offset_bits;
    set = 0; tag = '0; h1 = 0; e1 = 0;
    if (b < scl_pkg::ADDR_W) set = (it.address >> b) & ((1 << s) - 1);
    if (s + b < scl_pkg::ADDR_W) tag = it.address >> (s + b);
    r = '0;
    if (it.command != CMD_NONE) begin
      h1 = cache_access(set, tag, nways, e1);
      if (it.command == scl_pkg::CMD_MODIFY) begin
        dummy = cache_access(set, tag, nways, e2);
        r.second_done = 1'b1;
      end
    end
    r.first_hit = h1;
    r.first_eviction = e1;
    r.hit_total = sh_hits;
    r.miss_total = sh_misses;
    r.eviction_total = sh_evicts;
    return r;
  endfunction

  // Driver: present queued items, predict each one as it transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_results.push_back(predict_lookup(item_i));
        void'(pending_items.pop_front());
      end
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (bursty && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 15);
      // Drop push during a gap or a hold; otherwise offer the head item.
      if (pending_items.size() > (push && !full ? 0 : 0) && !sender_hold &&
          !(send_gap > 0)) begin
        push <= 1'b1;
        item_i <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation.
  always @(posedge clk_i) begin
    scl_pkg::result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (result_o.first_hit !== want.first_hit)
            report_mismatch("first_hit", result_o.first_hit, want.first_hit);
          if (result_o.first_eviction !== want.first_eviction)
            report_mismatch("first_eviction", result_o.first_eviction,
                            want.first_eviction);
          if (result_o.second_done !== want.second_done)
            report_mismatch("second_done", result_o.second_done, want.second_done);
          if (result_o.hit_total !== want.hit_total)
            report_mismatch("hit_total", result_o.hit_total, want.hit_total);
          if (result_o.miss_total !== want.miss_total)
            report_mismatch("miss_total", result_o.miss_total, want.miss_total);
          if (result_o.eviction_total !== want.eviction_total)
            report_mismatch("eviction_total", result_o.eviction_total,
                            want.eviction_total);
        end
      end
      if (recv_gap > 0) recv_gap <= recv_gap - 1;
      else if (bursty && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 15);
      pop <= !receiver_hold && !(recv_gap > 0);
    end
  end

  // APB write: setup cycle, then access cycle; pready is tied high.
  task automatic write_reg(input logic [scl_pkg::APB_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait until every expected result has popped, plus the pipeline depth.
  task automatic drain;
    while (pending_items.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(input int sb, input int wy, input int ob);
    drain();
    write_reg(scl_pkg::REG_SET_BITS, sb);
    write_reg(scl_pkg::REG_WAYS_IN_USE, wy);
    write_reg(scl_pkg::REG_OFFSET_BITS, ob);
    sh_cfg.set_bits = sb; sh_cfg.ways_in_use = wy; sh_cfg.offset_bits = ob;
  endtask

  function automatic scl_pkg::item_t make_item(input logic [1:0] cmd,
                                               input logic [31:0] addr);
    scl_pkg::item_t it;
    it.command = cmd; it.address = addr;
    return it;
  endfunction

  // Draw an address from a small pool of tags so sets fill and lines get reused.
  function automatic logic [31:0] local_addr;
    logic [31:0] a;
    a = $urandom_range(0, 63) << (sh_cfg.offset_bits + 6);
    a = a | ($urandom_range(0, 3) << sh_cfg.offset_bits) | ($urandom & 32'hF);
    if ($urandom_range(0, 7) == 0) a = $urandom;
    return a;
  endfunction

  task automatic random_phase(input int count);
    int k, c;
    for (k = 0; k < count; k++) begin
      c = $urandom_range(0, 19);
      pending_items.push_back(make_item(c == 0 ? CMD_NONE : c % 3, local_addr()));
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < LINES; k++) begin
      sh_valid[k] = 0; sh_tag[k] = '0; sh_age[k] = 0;
    end
    sh_hits = '0; sh_misses = '0; sh_evicts = '0;
    sh_cfg.set_bits = 4; sh_cfg.ways_in_use = 1; sh_cfg.offset_bits = 4;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, every command, extreme addresses, thrash one set.
    pending_items.push_back(make_item(scl_pkg::CMD_LOAD, 32'h0));
    pending_items.push_back(make_item(scl_pkg::CMD_LOAD, 32'h0));
    pending_items.push_back(make_item(scl_pkg::CMD_STORE, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(scl_pkg::CMD_MODIFY, 32'h0000_1000));
    pending_items.push_back(make_item(CMD_NONE, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(scl_pkg::CMD_LOAD, 32'h0000_1000));
    set_config(6, 8, 0);
    for (k = 0; k < 10; k++)
      pending_items.push_back(make_item(k % 3, k << 6));
    pending_items.push_back(make_item(scl_pkg::CMD_LOAD, 32'h0));
    set_config(0, 0, 31);       // zero set bits, zero ways, offset just below the width
    pending_items.push_back(make_item(scl_pkg::CMD_MODIFY, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(scl_pkg::CMD_LOAD, 32'h1234_5678));
    set_config(7, 15, 28);      // saturated sets and ways, set+offset reach width
    pending_items.push_back(make_item(scl_pkg::CMD_STORE, 32'hF000_0000));
    pending_items.push_back(make_item(scl_pkg::CMD_LOAD, 32'hAAAA_5555));

    // Long receiver hold, timed in its own process, while the sender keeps
    // offering, so full rises.
    set_config(2, 4, 4);
    receiver_hold = 1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        receiver_hold = 0;
      end
    join_none
    random_phase(40);

    // Sender pause until everything has come back.
    drain();
    set_config(3, 2, 5);
    random_phase(300);
    set_config(6, 8, 2);
    random_phase(300);
    set_config(1, 3, 16);
    random_phase(300);
    set_config(4, 1, 4);
    random_phase(200);
    // Last part: no idling on either side.
    drain();
    bursty = 0;
    set_config(5, 6, 3);
    random_phase(160);
    drain();
    stim_done = 1;
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
